>>> design/pqcc_pkg.sv
`default_nettype none

package pqcc_pkg;

  // Fixed widths of the item fields and of the key.
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned KEY_W   = 15;
  localparam int unsigned DIST_W  = 10;

  // Default geometry.
  localparam int unsigned CACHE_DEPTH_DEF   = 32768;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  // Register reset values.
  localparam logic [SIZE_W-1:0]  PALETTE_SIZE_RST = 9'd256;
  localparam logic [IDX_W-1:0]   TRANSP_IDX_RST   = 8'd0;
  localparam logic [COLOR_W-1:0] ALPHA_THR_RST    = 8'd128;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_PALETTE_SIZE   = 2'd0,
    CFG_TRANSP_INDEX   = 2'd1,
    CFG_TRANSP_ENABLE  = 2'd2,
    CFG_ALPHA_THRESH   = 2'd3
  } cfg_e;

  // Search request: start strobe and the midpoint of the crushed colour.
  typedef struct packed {
    logic               start;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } srch_req_t;

  // Search response: done stays high until the next start.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] best;
  } srch_rsp_t;

  // Midpoint of the 8-value bucket a channel falls in.
  function automatic logic [COLOR_W-1:0] mid_color(input logic [COLOR_W-1:0] c);
    return {c[COLOR_W-1:3], 3'b100};
  endfunction

endpackage

`default_nettype wire

>>> design/pqcc_cache.sv
`default_nettype none

module pqcc_cache
  import pqcc_pkg::*;
#(
  parameter int unsigned CACHE_DEPTH = CACHE_DEPTH_DEF,
  localparam int unsigned SLOT_W  = $clog2(CACHE_DEPTH),
  localparam int unsigned TAG_W   = KEY_W - SLOT_W + 1,
  localparam int unsigned ENTRY_W = 1 + TAG_W + IDX_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rd_en_i,
  input  wire logic [SLOT_W-1:0]  rd_slot_i,
  output logic      [ENTRY_W-1:0] rd_data_o,
  input  wire logic               wr_en_i,
  input  wire logic [SLOT_W-1:0]  wr_slot_i,
  input  wire logic [ENTRY_W-1:0] wr_data_i,
  input  wire logic               clr_i,
  output logic                    busy_o
);

  logic [ENTRY_W-1:0] mem [CACHE_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic               busy_q, busy_d;
  logic [SLOT_W-1:0]  ptr_q, ptr_d;

  // The sweep runs once after reset and again for every clear request.
  always_comb begin
    busy_d = busy_q;
    ptr_d  = ptr_q;
    if (clr_i) begin
      busy_d = 1'b1;
      ptr_d  = '0;
    end else if (busy_q) begin
      ptr_d = ptr_q + SLOT_W'(1);
      if (ptr_q == SLOT_W'(CACHE_DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      ptr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ptr_q  <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[ptr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_slot_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_slot_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

>>> design/pqcc_search.sv
`default_nettype none

module pqcc_search
  import pqcc_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [IDX_W-1:0]     wr_entry_i,
  input  wire logic [3*COLOR_W-1:0] wr_color_i,
  input  wire logic [SIZE_W-1:0]    count_i,
  input  wire srch_req_t            req_i,
  output srch_rsp_t                 rsp_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

  logic [3*COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [3*COLOR_W-1:0] rd_q;

  logic              wr_in_range;
  logic [CW-1:0]     cnt_sat;
  logic [CW-1:0]     issue_nx;

  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     issue_q;
  logic              issuing_q;
  logic              cmp_valid_q;
  logic              cmp_last_q;
  logic              found_q;
  logic              done_q;
  logic [AW-1:0]     cmp_idx_q;
  logic [AW-1:0]     best_q;
  logic [DIST_W-1:0] least_q;
  logic [COLOR_W-1:0] tr_q, tg_q, tb_q;

  logic [DIST_W-1:0] gap_sum;
  logic              better;

  function automatic logic [DIST_W-1:0] absdiff(input logic [COLOR_W-1:0] a,
                                                input logic [COLOR_W-1:0] b);
    return (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
  endfunction

  assign wr_in_range = {1'b0, wr_entry_i} < SIZE_W'(PALETTE_DEPTH);
  assign cnt_sat     = (count_i > SIZE_W'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                          : count_i[CW-1:0];
  assign issue_nx    = issue_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      mem[wr_entry_i[AW-1:0]] <= wr_color_i;
    end
    if (issuing_q) begin
      rd_q <= mem[issue_q[AW-1:0]];
    end
  end

  assign gap_sum = absdiff(tr_q, rd_q[3*COLOR_W-1:2*COLOR_W])
                 + absdiff(tg_q, rd_q[2*COLOR_W-1:COLOR_W])
                 + absdiff(tb_q, rd_q[COLOR_W-1:0]);
  // Strict less-than keeps the lowest index on a tie.
  assign better = !found_q || (gap_sum < least_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      issue_q     <= '0;
      issuing_q   <= 1'b0;
      cmp_valid_q <= 1'b0;
      cmp_last_q  <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else if (req_i.start) begin
      cnt_q       <= cnt_sat;
      issue_q     <= '0;
      issuing_q   <= (cnt_sat != '0);
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= (cnt_sat == '0);
    end else begin
      cmp_valid_q <= issuing_q;
      if (issuing_q) begin
        issue_q    <= issue_nx;
        cmp_last_q <= (issue_nx == cnt_q);
        if (issue_nx == cnt_q) begin
          issuing_q <= 1'b0;
        end
      end
      if (cmp_valid_q) begin
        if (better) begin
          found_q <= 1'b1;
        end
        if (cmp_last_q) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      tr_q   <= req_i.red;
      tg_q   <= req_i.green;
      tb_q   <= req_i.blue;
      best_q <= '0;
    end else begin
      if (issuing_q) begin
        cmp_idx_q <= issue_q[AW-1:0];
      end
      if (cmp_valid_q && better) begin
        least_q <= gap_sum;
        best_q  <= cmp_idx_q;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.best = IDX_W'(best_q);

  a_best_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && cnt_q != '0) |-> (CW'(best_q) < cnt_q))
    else $error("search answer lies outside the searched entries");

  a_no_compare_after_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_valid_q |-> !done_q)
    else $error("search finished with a compare still pending");

  a_issue_within_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing_q |-> (issue_q < cnt_q))
    else $error("palette read issued beyond the searched entries");

endmodule

`default_nettype wire

>>> design/palette_quantizer_with_color_cache_top.sv
// Items are taken only in ST_IDLE. Cache hit or transparent pixel: the cache entry is read
// at the edge that accepts the item; ST_CHECK loads the result once the output can take it.
// Cache miss: ST_CHECK starts a search over N entries and ST_SEARCH loads its result,
// N being palette_size capped at PALETTE_DEPTH: one palette memory read per entry searched.
// A palette write lands at the edge that accepts it; a clear item, and reset, sweep every
// cache slot, one slot a cycle, with in_ready_o low. Reset restores the register defaults.
`default_nettype none

module palette_quantizer_with_color_cache_top
  import pqcc_pkg::*;
#(
  parameter int unsigned CACHE_DEPTH   = CACHE_DEPTH_DEF,
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write port.
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [SIZE_W-1:0]  cfg_data_i,
  // Input items.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [IDX_W-1:0]   entry_i,
  input  wire logic [COLOR_W-1:0] red_i,
  input  wire logic [COLOR_W-1:0] green_i,
  input  wire logic [COLOR_W-1:0] blue_i,
  input  wire logic [COLOR_W-1:0] alpha_i,
  // Result items.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [IDX_W-1:0]   pal_idx_o,
  output logic                    is_transparent_o
);

  // The cache is direct mapped: the low bits of the RGB555 key pick the slot and
  // the remaining bits are kept as a tag. CACHE_DEPTH is expected to be a power
  // of two. The tag carries one spare bit so that it is never empty.
  localparam int unsigned SLOT_W  = $clog2(CACHE_DEPTH);
  localparam int unsigned TAG_W   = KEY_W - SLOT_W + 1;
  localparam int unsigned ENTRY_W = 1 + TAG_W + IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_SEARCH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [SIZE_W-1:0]  size_q;
  logic [IDX_W-1:0]   tidx_q;
  logic               ten_q;
  logic [COLOR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= PALETTE_SIZE_RST;
      tidx_q <= TRANSP_IDX_RST;
      ten_q  <= 1'b0;
      thr_q  <= ALPHA_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_PALETTE_SIZE:  size_q <= cfg_data_i;
        CFG_TRANSP_INDEX:  tidx_q <= cfg_data_i[IDX_W-1:0];
        CFG_TRANSP_ENABLE: ten_q  <= cfg_data_i[0];
        CFG_ALPHA_THRESH:  thr_q  <= cfg_data_i[COLOR_W-1:0];
      endcase
    end
  end

  // Input decode. An item is taken only while idle and the cache is not being swept.
  logic              clr_busy;
  logic              accept;
  kind_e             kind;
  logic [KEY_W-1:0]  key_in;
  logic              transp_in;

  assign in_ready_o = (state_q == ST_IDLE) && !clr_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = kind_e'(kind_i);
  assign key_in     = {red_i[COLOR_W-1:3], green_i[COLOR_W-1:3], blue_i[COLOR_W-1:3]};
  assign transp_in  = ten_q && (alpha_i < thr_q);

  // The pixel being worked on is held here until its result has been loaded.
  logic [KEY_W-1:0]   key_q;
  logic               transp_q;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (accept && kind == KIND_PIXEL) begin
      key_q    <= key_in;
      transp_q <= transp_in;
      red_q    <= red_i;
      green_q  <= green_i;
      blue_q   <= blue_i;
    end
  end

  logic [KEY_W:0]   tag_full;
  logic [TAG_W-1:0] tag_cur;
  assign tag_full = {1'b0, key_q} >> SLOT_W;
  assign tag_cur  = tag_full[TAG_W-1:0];

  // Colour cache. The slot is read at the very edge that accepts the pixel, so
  // the entry is on hand in the following cycle.
  logic [ENTRY_W-1:0] rd_entry;
  logic               cache_wr_en;
  logic [ENTRY_W-1:0] cache_wr_data;
  logic               hit;

  srch_req_t srch_req;
  srch_rsp_t srch_rsp;

  assign cache_wr_data = {1'b1, tag_cur, srch_rsp.best};

  pqcc_cache #(
    .CACHE_DEPTH(CACHE_DEPTH)
  ) u_cache (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && kind == KIND_PIXEL),
    .rd_slot_i (key_in[SLOT_W-1:0]),
    .rd_data_o (rd_entry),
    .wr_en_i   (cache_wr_en),
    .wr_slot_i (key_q[SLOT_W-1:0]),
    .wr_data_i (cache_wr_data),
    .clr_i     (accept && kind == KIND_CLEAR),
    .busy_o    (clr_busy)
  );

  assign hit = rd_entry[ENTRY_W-1] && (rd_entry[IDX_W +: TAG_W] == tag_cur);

  // Palette store and nearest-colour search. A palette write lands at the edge
  // that accepts its item; searches only run while no item is being taken.
  pqcc_search #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept && kind == KIND_WRITE),
    .wr_entry_i (entry_i),
    .wr_color_i ({red_i, green_i, blue_i}),
    .count_i    (size_q),
    .req_i      (srch_req),
    .rsp_o      (srch_rsp)
  );

  // Result register. It is loaded when empty or being emptied in the same cycle,
  // so a new item may be accepted while an earlier result still waits.
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_tr_q;
  logic             can_load;
  logic             load_out;
  logic [IDX_W-1:0] load_idx;
  logic             load_tr;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    load_out       = 1'b0;
    load_idx       = srch_rsp.best;
    load_tr        = 1'b0;
    cache_wr_en    = 1'b0;
    srch_req.start = 1'b0;
    srch_req.red   = mid_color(red_q);
    srch_req.green = mid_color(green_q);
    srch_req.blue  = mid_color(blue_q);
    unique case (state_q)
      ST_IDLE: begin
        if (accept && kind == KIND_PIXEL) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (transp_q) begin
          load_idx = tidx_q;
          load_tr  = 1'b1;
          if (can_load) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (hit) begin
          load_idx = rd_entry[IDX_W-1:0];
          if (can_load) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          srch_req.start = 1'b1;
          state_d        = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // The answer is stored in the cache and shown in the same cycle.
        if (srch_rsp.done && can_load) begin
          cache_wr_en = 1'b1;
          load_out    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_idx_q <= load_idx;
      out_tr_q  <= load_tr;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pal_idx_o        = out_idx_q;
  assign is_transparent_o = out_tr_q;

  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind == KIND_CLEAR) |=> !in_ready_o)
    else $error("item taken while the cache sweep should be running");

  a_miss_fills_cache : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && state_d == ST_IDLE) |-> cache_wr_en)
    else $error("search finished without storing its answer in the cache");

  a_no_fill_during_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cache_wr_en |-> (!clr_busy && srch_rsp.done))
    else $error("cache fill collides with the clearing sweep");

endmodule

`default_nettype wire

>>> tb/sv/quantizer_checker.sv
`timescale 1ns / 1ps

module quantizer_checker
  import pqcc_pkg::*;
#(
  parameter int unsigned CACHE_DEPTH   = CACHE_DEPTH_DEF,
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [SIZE_W-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         kind_i,
  input  logic [IDX_W-1:0]   entry_i,
  input  logic [COLOR_W-1:0] red_i,
  input  logic [COLOR_W-1:0] green_i,
  input  logic [COLOR_W-1:0] blue_i,
  input  logic [COLOR_W-1:0] alpha_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [IDX_W-1:0]   pal_idx_i,
  input  logic               is_transparent_i,
  output int                 answers_pending_o,
  output int                 mismatches_o
);

  typedef struct packed {
    logic [IDX_W-1:0] pal_index;
    logic             transparent;
  } answer_t;

  logic [3*COLOR_W-1:0] palette [PALETTE_DEPTH];
  bit                   slot_valid [CACHE_DEPTH];
  logic [IDX_W-1:0]     slot_index [CACHE_DEPTH];
  int unsigned          slot_tag [CACHE_DEPTH];

  logic [SIZE_W-1:0]    size_reg;
  logic [IDX_W-1:0]     transp_idx_reg;
  logic                 transp_en_reg;
  logic [COLOR_W-1:0]   alpha_thr_reg;

  answer_t              answers [$];
  answer_t              want;
  int                   mismatches = 0;

  function automatic void drop_cache();
    foreach (slot_valid[s]) slot_valid[s] = 1'b0;
  endfunction

  function automatic int unsigned channel_gap(input logic [COLOR_W-1:0] x,
                                              input logic [COLOR_W-1:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  // Search the live part of the palette for the entry closest to the centre of the
  // pixel's colour bucket; a strict comparison keeps the lowest index on a tie.
  function automatic logic [IDX_W-1:0] nearest_entry(input logic [COLOR_W-1:0] r, g, b);
    logic [COLOR_W-1:0] rc, gc, bc;
    logic [3*COLOR_W-1:0] rgb;
    int unsigned count, gap_sum, least;
    logic [IDX_W-1:0] best;
    rc = (r & 8'hf8) | 8'h04;
    gc = (g & 8'hf8) | 8'h04;
    bc = (b & 8'hf8) | 8'h04;
    count = (size_reg > PALETTE_DEPTH) ? PALETTE_DEPTH : size_reg;
    best = '0;
    least = 32'hffff_ffff;
    for (int unsigned i = 0; i < count; i++) begin
      rgb = palette[i];
      gap_sum = channel_gap(rc, rgb[23:16]) + channel_gap(gc, rgb[15:8])
              + channel_gap(bc, rgb[7:0]);
      if (gap_sum < least) begin
        least = gap_sum;
        best = IDX_W'(i);
      end
    end
    return best;
  endfunction

  function automatic answer_t quantize_pixel(input logic [COLOR_W-1:0] r, g, b, a);
    logic [KEY_W-1:0] key;
    int unsigned slot, tag;
    if (transp_en_reg && a < alpha_thr_reg) begin
      return '{pal_index: transp_idx_reg, transparent: 1'b1};
    end
    key = {r[7:3], g[7:3], b[7:3]};
    slot = key % CACHE_DEPTH;
    tag = key / CACHE_DEPTH;
    if (!slot_valid[slot] || slot_tag[slot] != tag) begin
      slot_index[slot] = nearest_entry(r, g, b);
      slot_tag[slot] = tag;
      slot_valid[slot] = 1'b1;
    end
    return '{pal_index: slot_index[slot], transparent: 1'b0};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_cache();
      answers.delete();
      size_reg       = PALETTE_SIZE_RST;
      transp_idx_reg = TRANSP_IDX_RST;
      transp_en_reg  = 1'b0;
      alpha_thr_reg  = ALPHA_THR_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_PALETTE_SIZE:  size_reg       = cfg_data_i;
          CFG_TRANSP_INDEX:  transp_idx_reg = cfg_data_i[IDX_W-1:0];
          CFG_TRANSP_ENABLE: transp_en_reg  = cfg_data_i[0];
          CFG_ALPHA_THRESH:  alpha_thr_reg  = cfg_data_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      // Results are matched before new items are taken, so that a result can never be
      // paired with an item accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected result: expected none, got index %0d transparent %0b",
                   $time, pal_idx_i, is_transparent_i);
          mismatches++;
        end else begin
          want = answers.pop_front();
          if (pal_idx_i !== want.pal_index) begin
            $display("%0t: index mismatch: expected %0d, got %0d",
                     $time, want.pal_index, pal_idx_i);
            mismatches++;
          end
          if (is_transparent_i !== want.transparent) begin
            $display("%0t: is_transparent mismatch: expected %0b, got %0b",
                     $time, want.transparent, is_transparent_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (kind_e'(kind_i))
          KIND_WRITE: begin
            if (entry_i < PALETTE_DEPTH) palette[entry_i] = {red_i, green_i, blue_i};
          end
          KIND_PIXEL: answers.insert(answers.size(),
                                     quantize_pixel(red_i, green_i, blue_i, alpha_i));
          KIND_CLEAR: drop_cache();
          default: ;
        endcase
      end
    end
    answers_pending_o <= answers.size();
    mismatches_o      <= mismatches;
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// Top of the quantiser bench. This module only produces stimulus and gives the
// verdict; the checker beside the block watches both channels, keeps its own copy of
// the palette, the colour cache and the registers, and counts every mismatch.
module tb;
  import pqcc_pkg::*;

  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned HOT_KEYS    = 24;
  localparam int unsigned LONG_HOLD   = 300;
  // Longest a miss may take at full palette size, with some margin.
  localparam int unsigned SETTLE      = 300;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_we_i         = 1'b0;
  logic [1:0]         cfg_index_i      = '0;
  logic [SIZE_W-1:0]  cfg_data_i       = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i           = '0;
  logic [IDX_W-1:0]   entry_i          = '0;
  logic [COLOR_W-1:0] red_i            = '0;
  logic [COLOR_W-1:0] green_i          = '0;
  logic [COLOR_W-1:0] blue_i           = '0;
  logic [COLOR_W-1:0] alpha_i          = '0;
  logic               out_valid_o;
  logic               out_ready_i      = 1'b0;
  logic [IDX_W-1:0]   pal_idx_o;
  logic               is_transparent_o;

  int answers_pending;
  int mismatches;

  // When set, neither side idles; used for the closing phases of the run.
  bit steady = 1'b0;
  // The stimulus asks for a long receiver stall by raising the request count; the
  // receiver acknowledges once the stall is over.
  int rx_hold_reqs = 0;
  int rx_hold_done = 0;
  // Set whenever a cache sweep may still be running: from reset, and after a clear item.
  bit cache_swept = 1'b1;

  always #5 clk_i = ~clk_i;

  palette_quantizer_with_color_cache_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .entry_i          (entry_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .alpha_i          (alpha_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pal_idx_o        (pal_idx_o),
    .is_transparent_o (is_transparent_o)
  );

  quantizer_checker answer_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .kind_i            (kind_i),
    .entry_i           (entry_i),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .alpha_i           (alpha_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pal_idx_i         (pal_idx_o),
    .is_transparent_i  (is_transparent_o),
    .answers_pending_o (answers_pending),
    .mismatches_o      (mismatches)
  );

  // Offer one item and hold it until the block takes it. Before the item a short
  // burst with valid low is sometimes inserted, unless the run is in its steady part.
  task automatic send_item(input kind_e kind, input logic [IDX_W-1:0] entry,
                           input logic [COLOR_W-1:0] r, g, b, a);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    entry_i    <= entry;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    alpha_i    <= a;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (kind == KIND_CLEAR) cache_swept = 1'b1;
  endtask

  // Stop offering items, wait for every outstanding result, then let the block come
  // to rest. A cache sweep produces no result and keeps the block busy for a full pass
  // over the cache, so that case waits for the whole sweep.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (answers_pending != 0) @(posedge clk_i);
    repeat (cache_swept ? CACHE_DEPTH_DEF + 16 : SETTLE) @(posedge clk_i);
    cache_swept = 1'b0;
  endtask

  // Write all four registers on consecutive edges; the enable is lowered only after
  // the last one, so it is never dropped and raised again within one step.
  task automatic configure(input logic [SIZE_W-1:0] size, input logic [IDX_W-1:0] tidx,
                           input logic ten, input logic [COLOR_W-1:0] thr);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PALETTE_SIZE;
    cfg_data_i  <= size;
    @(posedge clk_i);
    cfg_index_i <= CFG_TRANSP_INDEX;
    cfg_data_i  <= SIZE_W'(tidx);
    @(posedge clk_i);
    cfg_index_i <= CFG_TRANSP_ENABLE;
    cfg_data_i  <= SIZE_W'(ten);
    @(posedge clk_i);
    cfg_index_i <= CFG_ALPHA_THRESH;
    cfg_data_i  <= SIZE_W'(thr);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver: ready is mostly high, with random idle bursts, and one long stall on request
  // so that the block backs up and refuses further items.
  initial begin : receiver
    int unsigned idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_reqs != rx_hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_hold_done++;
        out_ready_i <= 1'b1;
      end else if (idle_left != 0) begin
        out_ready_i <= 1'b0;
        idle_left--;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        idle_left = $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // The bound is several times the slowest legal run, with every pixel a full-palette miss.
  initial begin : watchdog
    #(40_000_000);
    $display("palette_quantizer_with_color_cache_top test failed");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0]   hot [HOT_KEYS];
    logic [SIZE_W-1:0]  sizes [PHASES];
    logic [KEY_W-1:0]   key;
    logic [COLOR_W-1:0] a;
    int unsigned        pick;
    int unsigned        clears_left;

    // Mostly small palettes so that misses stay short, with the full, empty and
    // oversized settings each visited once or twice.
    sizes = '{9'd256, 9'd1, 9'd6, 9'd0, 9'd511, 9'd16, 9'd3, 9'd257, 9'd9, 9'd2,
              9'd12, 9'd5};
    clears_left = 5;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block sweeps its cache after reset; let that finish before configuring.
    drain_and_settle();

    // Directed part: a four-entry palette with black twice, so that the tie goes to
    // the lower index, and transparency on with the usual threshold.
    configure(9'd4, 8'hff, 1'b1, 8'd128);
    send_item(KIND_WRITE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(KIND_WRITE, 8'd1, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(KIND_WRITE, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(KIND_WRITE, 8'd3, 8'haa, 8'h55, 8'haa, 8'h00);
    send_item(KIND_WRITE, 8'd255, 8'h12, 8'h34, 8'h56, 8'hff);
    // Black misses first, then the same bucket with other low bits must hit.
    send_item(KIND_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'hff);
    send_item(KIND_PIXEL, 8'd0, 8'hff, 8'hff, 8'hff, 8'd128);
    send_item(KIND_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'd127);
    send_item(KIND_PIXEL, 8'd0, 8'h01, 8'h02, 8'h03, 8'd200);
    send_item(KIND_PIXEL, 8'd0, 8'haa, 8'h55, 8'haa, 8'hff);
    // The unused kind must be swallowed without a result.
    send_item(KIND_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    // Overwriting an entry leaves the cached answer for black in place until a clear.
    send_item(KIND_WRITE, 8'd0, 8'hff, 8'hff, 8'hff, 8'h00);
    send_item(KIND_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'hff);
    send_item(KIND_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(KIND_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'hff);
    send_item(KIND_PIXEL, 8'd0, 8'hff, 8'hff, 8'hff, 8'h00);

    // Fill the whole palette so that any size setting searches written entries only.
    for (int e = 0; e < 256; e++) begin
      send_item(KIND_WRITE, IDX_W'(e), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
    end

    // Random phases. Each one waits for the block to go quiet, reprograms every
    // register, then sends pixels drawn mostly from a small pool of colour buckets so
    // that the cache warms up, mixed with palette writes, stray items and rare clears.
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      steady = (p >= PHASES - 2);
      configure(sizes[p],
                (p % 3 == 0) ? 8'hff : (p % 3 == 1) ? 8'h00 : 8'($urandom),
                (p % 4 != 3),
                (p % 4 == 0) ? 8'hff : (p % 4 == 1) ? 8'h00 : 8'($urandom));
      if (p == 2) rx_hold_reqs++;
      foreach (hot[k]) hot[k] = KEY_W'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_item(KIND_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
        end else if (pick < 8) begin
          send_item(KIND_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
        end else if (pick < 9 && clears_left != 0) begin
          clears_left--;
          send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
        end else begin
          key = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom)
                                            : hot[$urandom_range(0, HOT_KEYS - 1)];
          case ($urandom_range(0, 5))
            0:       a = 8'h00;
            1:       a = 8'hff;
            default: a = 8'($urandom);
          endcase
          send_item(KIND_PIXEL, 8'($urandom), {key[14:10], 3'($urandom)},
                    {key[9:5], 3'($urandom)}, {key[4:0], 3'($urandom)}, a);
        end
      end
    end

    drain_and_settle();
    if (mismatches == 0 && answers_pending == 0) begin
      $display("palette_quantizer_with_color_cache_top test passed");
    end else begin
      $display("palette_quantizer_with_color_cache_top test failed");
    end
    $finish;
  end

endmodule

>>> palette_quantizer_with_color_cache_top.f
design/pqcc_pkg.sv
design/pqcc_cache.sv
design/pqcc_search.sv
design/palette_quantizer_with_color_cache_top.sv
tb/sv/quantizer_checker.sv
tb/sv/tb.sv
